@@ hdl/bferm_pkg.sv @@
// Shared types, constants and functions of the bit and frame error rate monitor.
`timescale 1ns / 1ps

package bferm_pkg;

    localparam int DEF_WORD_BITS      = 64;
    localparam int DEF_MAX_FRAME_BITS = 65536;

    localparam int DATA_W   = 64;
    localparam int POS_W    = 17;
    localparam int POS_MAX  = 131071;
    localparam int CNT_N_W  = 7;
    localparam int MAXC_W   = 32;
    localparam int BITS_W   = 48;
    localparam int FRM_W    = 40;
    localparam int CIDX_W   = 2;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 152;

    localparam logic [CIDX_W-1:0] CFG_FRAME_BITS       = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_FRAME_ERRORS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_FRAMES       = 2'd2;

    localparam logic OP_COMPARE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  frame_bits;
        logic [MAXC_W-1:0] max_frame_errors;
        logic [MAXC_W-1:0] max_frames;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] ref_word;
        logic [DATA_W-1:0] decoded_word;
    } item_t;

    typedef struct packed {
        logic [FRM_W-1:0]  frames_total;
        logic [POS_W-1:0]  frame_bit_errors;
        logic              frame_error;
        logic [BITS_W-1:0] bit_errors_total;
        logic [FRM_W-1:0]  frame_errors_total;
        logic              done_res;
    } result_t;

    // Nibble counts summed pairwise, so the adder depth grows with log2 of the width.
    function automatic logic [CNT_N_W-1:0] popcount64(input logic [DATA_W-1:0] x);
        logic [2:0] s4  [16];
        logic [3:0] s8  [8];
        logic [4:0] s16 [4];
        logic [5:0] s32 [2];
        for (int i = 0; i < 16; i++)
        begin
            s4[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
        end
        for (int i = 0; i < 8; i++)
        begin
            s8[i] = 4'(s4[2*i]) + 4'(s4[2*i+1]);
        end
        for (int i = 0; i < 4; i++)
        begin
            s16[i] = 5'(s8[2*i]) + 5'(s8[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            s32[i] = 6'(s16[2*i]) + 6'(s16[2*i+1]);
        end
        return CNT_N_W'(s32[0]) + CNT_N_W'(s32[1]);
    endfunction

endpackage

@@ hdl/bferm_cfg.sv @@
// Configuration register file of the monitor.
`timescale 1ns / 1ps

module bferm_cfg
    import bferm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [MAXC_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_BITS:       cfg_next.frame_bits       = cfg_data[POS_W-1:0];
                CFG_MAX_FRAME_ERRORS: cfg_next.max_frame_errors = cfg_data;
                CFG_MAX_FRAMES:       cfg_next.max_frames       = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_bits       <= POS_W'(64);
            cfg_reg.max_frame_errors <= '0;
            cfg_reg.max_frames       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/bferm_in_reg.sv @@
// Input register stage holding one accepted item.
`timescale 1ns / 1ps

module bferm_in_reg
    import bferm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

@@ hdl/bferm_count.sv @@
// Frame bookkeeping: bit compare, popcount, saturating totals and limit check.
`timescale 1ns / 1ps

module bferm_count
    import bferm_pkg::*;
#(
    parameter int WORD_BITS      = DEF_WORD_BITS,
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    localparam logic [POS_W-1:0] FB_LIMIT =
        (MAX_FRAME_BITS > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(MAX_FRAME_BITS);
    localparam logic [POS_W-1:0] WORD_N = POS_W'(WORD_BITS);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  acc_reg, acc_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [FRM_W-1:0]  ferr_reg, ferr_next;
    logic [FRM_W-1:0]  frames_reg, frames_next;

    logic [POS_W-1:0]   fb;
    logic [POS_W-1:0]   remaining;
    logic [POS_W-1:0]   n_full;
    logic [CNT_N_W-1:0] n;
    logic [DATA_W-1:0]  mask;
    logic [CNT_N_W-1:0] errs;
    logic [POS_W:0]     acc_sum;
    logic [POS_W-1:0]   acc_new;
    logic [POS_W:0]     pos_sum;
    logic               frame_end;
    logic [BITS_W:0]    bits_sum;
    logic [BITS_W-1:0]  bits_new;
    logic [FRM_W-1:0]   ferr_new;
    logic [FRM_W-1:0]   frames_new;
    logic               is_clear;

    always_comb
    begin
        if (cfg.frame_bits == '0)
            fb = POS_W'(1);
        else if (cfg.frame_bits > FB_LIMIT)
            fb = FB_LIMIT;
        else
            fb = cfg.frame_bits;

        remaining = (pos_reg < fb) ? (fb - pos_reg) : '0;
        n_full    = (remaining < WORD_N) ? remaining : WORD_N;
        n         = n_full[CNT_N_W-1:0];

        for (int i = 0; i < DATA_W; i++)
        begin
            mask[i] = (i < WORD_BITS) && (CNT_N_W'(i) < n);
        end
        errs = popcount64((item.ref_word ^ item.decoded_word) & mask);

        acc_sum = {1'b0, acc_reg} + (POS_W + 1)'(errs);
        acc_new = acc_sum[POS_W] ? '1 : acc_sum[POS_W-1:0];

        // A frame length lowered below the consumed count ends the frame here.
        pos_sum   = {1'b0, pos_reg} + (POS_W + 1)'(n);
        frame_end = pos_sum >= {1'b0, fb};

        bits_sum   = {1'b0, bits_reg} + (BITS_W + 1)'(acc_new);
        bits_new   = bits_sum[BITS_W] ? '1 : bits_sum[BITS_W-1:0];
        ferr_new   = (acc_new != '0 && ferr_reg != '1) ? ferr_reg + 1'b1 : ferr_reg;
        frames_new = (frames_reg != '1) ? frames_reg + 1'b1 : frames_reg;

        is_clear  = item.op == OP_CLEAR;
        res_valid = step && !is_clear && frame_end;

        res.frames_total       = frames_new;
        res.frame_bit_errors   = acc_new;
        res.frame_error        = acc_new != '0;
        res.bit_errors_total   = bits_new;
        res.frame_errors_total = ferr_new;
        res.done_res =
            (cfg.max_frame_errors != '0 && ferr_new >= FRM_W'(cfg.max_frame_errors)) ||
            (cfg.max_frames != '0 && frames_new >= FRM_W'(cfg.max_frames));

        pos_next    = pos_reg;
        acc_next    = acc_reg;
        bits_next   = bits_reg;
        ferr_next   = ferr_reg;
        frames_next = frames_reg;
        if (step)
        begin
            priority if (is_clear)
            begin
                pos_next    = '0;
                acc_next    = '0;
                bits_next   = '0;
                ferr_next   = '0;
                frames_next = '0;
            end
            else if (frame_end)
            begin
                pos_next    = '0;
                acc_next    = '0;
                bits_next   = bits_new;
                ferr_next   = ferr_new;
                frames_next = frames_new;
            end
            else
            begin
                pos_next = pos_sum[POS_W-1:0];
                acc_next = acc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            acc_reg    <= '0;
            bits_reg   <= '0;
            ferr_reg   <= '0;
            frames_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            bits_reg   <= bits_next;
            ferr_reg   <= ferr_next;
            frames_reg <= frames_next;
        end
    end

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.op == OP_CLEAR |=> frames_reg == '0 && bits_reg == '0 && pos_reg == '0)
        else $error("counters not cleared by a clear item");

    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.frame_error == (res.frame_bit_errors != '0))
        else $error("frame error flag disagrees with frame bit errors");

    a_ferr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.frame_errors_total <= res.frames_total)
        else $error("more erroneous frames than frames");

    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.op == OP_COMPARE && !frame_end |=> $stable(frames_reg))
        else $error("frame count moved inside a frame");

endmodule

@@ hdl/bferm_out_reg.sv @@
// Result register toward the master-side stream.
`timescale 1ns / 1ps

module bferm_out_reg
    import bferm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

@@ hdl/bit_frame_error_rate_monitor_top.sv @@
// Top level of the bit and frame error rate monitor.
`timescale 1ns / 1ps

// The slave-side stream carries one item per 64-bit word pair: tdata holds the
// reference word and the decoded word, tuser selects compare or clear. The
// block counts bit errors over frames of frame_bits bits and sends one item on
// the master-side stream when a frame completes, with the frame's error count,
// the saturating totals and a done flag for the configured limits.
// An accepted item waits in the input register until the output register is
// free; when it leaves, the result of a frame it completes is loaded into the
// output register at the same edge. One item is taken every cycle while the
// output side keeps up; the combinational popcount and update set that rate.
// When the receiver stalls with a result waiting, the input register still
// takes one more item, then tready drops until the result register empties.
// Reset sets frame_bits to 64, both limits to zero (no limit) and all counters
// to zero. The configuration channel is always ready; the user writes it only
// while idle, which the block never checks; a write to index 3 is ignored.

module bit_frame_error_rate_monitor_top
    import bferm_pkg::*;
#(
    parameter int WORD_BITS      = DEF_WORD_BITS,
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [MAXC_W-1:0]      cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // ref_word [63:0], decoded_word [127:64]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // frames_total [39:0], frame_bit_errors [56:40], frame_error [57],
    // bit_errors_total [105:58], frame_errors_total [145:106], done_res [146],
    // zeros [151:147]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.op           = s_axis_tuser;
    assign in_item.ref_word     = s_axis_tdata[DATA_W-1:0];
    assign in_item.decoded_word = s_axis_tdata[2*DATA_W-1:DATA_W];

    assign advance = item_valid && out_free;

    bferm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bferm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bferm_count #(
        .WORD_BITS      (WORD_BITS),
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    bferm_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {
        5'b0,
        out_res.done_res,
        out_res.frame_errors_total,
        out_res.bit_errors_total,
        out_res.frame_error,
        out_res.frame_bit_errors,
        out_res.frames_total
    };

endmodule

@@ dv/tb_bit_frame_error_rate_monitor_top.sv @@
// Self-checking testbench for the bit and frame error rate monitor top level.
`timescale 1ns / 1ps

module tb_bit_frame_error_rate_monitor_top
    import bferm_pkg::*;
();

    localparam int     CLK_HALF      = 6;
    localparam int     RESET_CYCLES  = 9;
    localparam longint CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     RANDOM_ITEMS  = 600;
    localparam int     FRAME_CAP     = DEF_MAX_FRAME_BITS;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [63:0] ACC_MAX  = 64'(POS_MAX);
    localparam logic [63:0] BITS_MAX = (64'd1 << BITS_W) - 64'd1;
    localparam logic [63:0] FRM_MAX  = (64'd1 << FRM_W) - 64'd1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CIDX_W-1:0]      cfg_index;
    logic [MAXC_W-1:0]      cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit_frame_error_rate_monitor_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the registers and counters.
    logic [POS_W-1:0]  fb_reg;
    logic [MAXC_W-1:0] frame_err_limit;
    logic [MAXC_W-1:0] frame_limit;
    int                bits_in_frame;
    logic [63:0]       errs_in_frame;
    logic [63:0]       bit_err_total;
    logic [63:0]       frame_err_total;
    logic [63:0]       frame_total;

    result_t frame_summaries[$];
    int      mismatches;
    longint  cycles;
    bit      quiet_in;
    bit      quiet_out;
    int      stall_left;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] lim);
        if (a >= lim || b > lim - a)
            return lim;
        return a + b;
    endfunction

    function automatic void clear_totals();
        bits_in_frame   = 0;
        errs_in_frame   = '0;
        bit_err_total   = '0;
        frame_err_total = '0;
        frame_total     = '0;
    endfunction

    // Consumes one accepted item and queues the frame summary it completes, if any.
    function automatic void account_word(input logic op, input logic [DATA_W-1:0] rw,
                                         input logic [DATA_W-1:0] dw);
        int                fb;
        int                take;
        logic [DATA_W-1:0] mask;
        logic [63:0]       errs;
        result_t           s;
        if (op == OP_CLEAR)
        begin
            clear_totals();
            return;
        end
        fb = int'(fb_reg);
        if (fb == 0)
            fb = 1;
        if (fb > FRAME_CAP)
            fb = FRAME_CAP;
        // A frame already past a lowered length takes no bits from this word.
        take = (bits_in_frame < fb) ? fb - bits_in_frame : 0;
        if (take > DATA_W)
            take = DATA_W;
        mask = (take >= DATA_W) ? '1 : ((64'd1 << take) - 64'd1);
        errs = 64'($countones((rw ^ dw) & mask));
        errs_in_frame = sat_add(errs_in_frame, errs, ACC_MAX);
        bits_in_frame += take;
        if (bits_in_frame < fb)
            return;
        bit_err_total = sat_add(bit_err_total, errs_in_frame, BITS_MAX);
        if (errs_in_frame != 0)
            frame_err_total = sat_add(frame_err_total, 64'd1, FRM_MAX);
        frame_total = sat_add(frame_total, 64'd1, FRM_MAX);
        s.frames_total       = frame_total[FRM_W-1:0];
        s.frame_bit_errors   = errs_in_frame[POS_W-1:0];
        s.frame_error        = (errs_in_frame != 0);
        s.bit_errors_total   = bit_err_total[BITS_W-1:0];
        s.frame_errors_total = frame_err_total[FRM_W-1:0];
        s.done_res = (frame_err_limit != 0 && frame_err_total >= 64'(frame_err_limit)) ||
                     (frame_limit != 0 && frame_total >= 64'(frame_limit));
        frame_summaries.push_back(s);
        bits_in_frame = 0;
        errs_in_frame = '0;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_summaries.size() == 0)
            begin
                report_error("frame summary item with none pending");
            end
            else
            begin
                want = frame_summaries.pop_front();
                check_field("frames_total", 64'(m_axis_tdata[39:0]), 64'(want.frames_total));
                check_field("frame_bit_errors", 64'(m_axis_tdata[56:40]),
                            64'(want.frame_bit_errors));
                check_field("frame_error", 64'(m_axis_tdata[57]), 64'(want.frame_error));
                check_field("bit_errors_total", 64'(m_axis_tdata[105:58]),
                            64'(want.bit_errors_total));
                check_field("frame_errors_total", 64'(m_axis_tdata[145:106]),
                            64'(want.frame_errors_total));
                check_field("done_res", 64'(m_axis_tdata[146]), 64'(want.done_res));
                check_field("padding", 64'(m_axis_tdata[151:147]), 64'd0);
            end
        end
    end

    // Mostly no idle cycle, sometimes a few, now and then a long stretch.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    initial
    begin : drive_ready
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet_out && $urandom_range(0, 99) < 25)
            begin
                m_axis_tready <= 1'b0;
                stall_left = pick_idle();
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [DATA_W-1:0] rw,
                             input logic [DATA_W-1:0] dw);
        int gap;
        gap = quiet_in ? 0 : pick_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dw, rw};
        do @(posedge clk); while (!s_axis_tready);
        account_word(op, rw, dw);
    endtask

    // Random error pattern: often clean or a single flip, sometimes dense.
    function automatic logic [DATA_W-1:0] rand_flips();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return '0;
        if (r < 70)
            return 64'd1 << $urandom_range(0, DATA_W - 1);
        if (r < 88)
            return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        if (r < 97)
            return {$urandom, $urandom};
        return '1;
    endfunction

    task automatic send_random_words(input int count);
        logic [DATA_W-1:0] rw;
        for (int i = 0; i < count; i++)
        begin
            rw = {$urandom, $urandom};
            send_word(OP_COMPARE, rw, rw ^ rand_flips());
        end
    endtask

    // Waits until the block has nothing left in flight.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (frame_summaries.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [MAXC_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_BITS:       fb_reg = val[POS_W-1:0];
            CFG_MAX_FRAME_ERRORS: frame_err_limit = val;
            CFG_MAX_FRAMES:       frame_limit = val;
            default:              ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [MAXC_W-1:0] fb, input logic [MAXC_W-1:0] mfe,
                              input logic [MAXC_W-1:0] mf);
        drain();
        write_reg(CFG_FRAME_BITS, fb);
        write_reg(CFG_MAX_FRAME_ERRORS, mfe);
        write_reg(CFG_MAX_FRAMES, mf);
    endtask

    // Reset configuration: one word per frame.
    task automatic test_default_frames();
        send_word(OP_COMPARE, '0, '0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, 64'h1, '0);
        send_word(OP_COMPARE, 64'h8000_0000_0000_0000, '0);
        send_word(OP_CLEAR, '1, '0);
        send_word(OP_COMPARE, '1, '1);
    endtask

    task automatic test_short_frames();
        set_config(1, 0, 0);
        send_word(OP_COMPARE, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        send_word(OP_COMPARE, 64'h1, '0);
        // A zero frame length behaves as a single bit.
        set_config(0, 0, 0);
        send_word(OP_COMPARE, '1, '0);
        // Bits above the register width are dropped, leaving 64.
        set_config(32'hFFFE_0040, 0, 0);
        send_word(OP_COMPARE, 64'hA5A5_0000_FFFF_0001, 64'h5A5A_0000_FFFF_0000);
        set_config(65, 0, 0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, '1, '0);
        set_config(129, 0, 0);
        send_random_words(3);
    endtask

    task automatic test_limits();
        set_config(64, 2, 0);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, '0, '0);
        send_word(OP_COMPARE, 64'h10, '0);
        send_word(OP_COMPARE, 64'h3, '0);
        drain();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        // The frame count is already past this limit.
        set_config(64, 0, 3);
        send_word(OP_COMPARE, '0, '0);
        send_word(OP_CLEAR, '0, '1);
        send_word(OP_COMPARE, '0, '0);
        send_word(OP_COMPARE, '0, '0);
        send_word(OP_COMPARE, '0, '0);
        set_config(64, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_COMPARE, '1, '0);
    endtask

    task automatic test_shrink_mid_frame();
        set_config(200, 0, 0);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, '1, '0);
        // 128 bits are in; the next word at length 100 only closes the frame.
        set_config(100, 0, 0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, '1, '0);
        send_word(OP_COMPARE, '1, '0);
    endtask

    task automatic test_largest_frames();
        // All-ones length is above the maximum and is clipped to it.
        set_config(32'hFFFF_FFFF, 5, 1);
        send_random_words(FRAME_CAP / DATA_W);
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               phase_len;
        int               r;
        logic [MAXC_W-1:0] fb;
        logic [MAXC_W-1:0] mfe;
        logic [MAXC_W-1:0] mf;
        logic [DATA_W-1:0] rw;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                fb = $urandom_range(1, 70);
            else if (r < 85)
                fb = $urandom_range(71, 300);
            else if (r < 97)
                fb = $urandom_range(301, 1500);
            else
                fb = 0;
            r = $urandom_range(0, 99);
            mfe = (r < 50) ? 0 : (r < 80) ? $urandom_range(1, 20) : $urandom;
            r = $urandom_range(0, 99);
            mf = (r < 50) ? 0 : (r < 80) ? $urandom_range(1, 40) : $urandom;
            // Any partial frame survives the reconfiguration.
            set_config(fb, mfe, mf);
            quiet_in  = ($urandom_range(0, 99) < 20);
            quiet_out = ($urandom_range(0, 99) < 20);
            phase_len = $urandom_range(60, 200);
            for (int i = 0; i < phase_len; i++)
            begin
                rw = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 3)
                    send_word(OP_CLEAR, rw, {$urandom, $urandom});
                else
                    send_word(OP_COMPARE, rw, rw ^ rand_flips());
            end
            sent += phase_len;
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_COMPARE;
        mismatches    = 0;
        cycles        = 0;
        quiet_in      = 1'b0;
        quiet_out     = 1'b0;
        fb_reg          = 64;
        frame_err_limit = '0;
        frame_limit     = '0;
        clear_totals();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_frames();
        test_short_frames();
        test_limits();
        test_shrink_mid_frame();
        test_random_traffic();
        test_largest_frames();

        drain();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
